// File: src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define ASSERT_CLK(lbl, c, r, p) \
  lbl: assert property (@(posedge c) disable iff (r) p) else $error("assertion failed");

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, c, p) \
  lbl: assert property (@(posedge c) p) else $error("assertion failed");

`endif

// File: src/ssc_pkg.sv
// shared types, widths and d8 helper functions for the stream side classifier
// no dependencies
package ssc_pkg;

  localparam int IN_W  = 40;
  localparam int OUT_W = 8;
  localparam int NB    = 8;

  typedef struct packed {
    logic trib;
    logic right;
  } lane_res_t;

  // d8 x offset: {0,1,1,1,0,-1,-1,-1}
  function automatic logic signed [1:0] d8_dx(input logic [2:0] d);
    logic signed [1:0] v;
    case (d)
      3'd1, 3'd2, 3'd3: v = 2'sd1;
      3'd5, 3'd6, 3'd7: v = -2'sd1;
      default:          v = 2'sd0;
    endcase
    return v;
  endfunction

  // d8 y offset: {1,1,0,-1,-1,-1,0,1}
  function automatic logic signed [1:0] d8_dy(input logic [2:0] d);
    logic signed [1:0] v;
    case (d)
      3'd0, 3'd1, 3'd7: v = 2'sd1;
      3'd3, 3'd4, 3'd5: v = -2'sd1;
      default:          v = 2'sd0;
    endcase
    return v;
  endfunction

  // z component of the cross product of two d8 unit offsets, range -2..2
  function automatic logic signed [2:0] cross_z(input logic [2:0] a, input logic [2:0] b);
    logic signed [2:0] ax, ay, bx, by;
    ax = 3'(d8_dx(a));
    ay = 3'(d8_dy(a));
    bx = 3'(d8_dx(b));
    by = 3'(d8_dy(b));
    return 3'(ax * by - ay * bx);
  endfunction

  // direction pointing the other way
  function automatic logic [2:0] opp_dir(input logic [2:0] d);
    return d + 3'd4;
  endfunction

endpackage

// File: src/ssc_lane.sv
// one neighbour lane: tributary detect and side decision for that tributary
// depends on ssc_pkg
module ssc_lane import ssc_pkg::*; (
  input  logic [2:0] idx,
  input  logic [2:0] flow_dir,
  input  logic [2:0] stream_dir,
  input  logic       nb_valid,
  input  logic [2:0] nb_dir,
  output lane_res_t  res
);

  logic [2:0]        trib_code;
  logic signed [2:0] za, zb, zc;
  logic              same_sign;

  // a tributary points back at the stream cell
  assign trib_code = opp_dir(idx);
  assign res.trib  = nb_valid && (nb_dir == trib_code);

  // cross products of flow, stream and tributary directions
  assign za = cross_z(flow_dir, stream_dir);
  assign zb = cross_z(flow_dir, trib_code);
  assign zc = cross_z(stream_dir, trib_code);

  // za*zb >= 0 with zb nonzero, else fall back on the sharp bend test
  assign same_sign = (zb != 3'sd0) && ((za == 3'sd0) || (za[2] == zb[2]));
  assign res.right = same_sign ? zb[2] : zc[2];

endmodule

// File: src/ssc_core.sv
// combinational side decision over all eight neighbours
// depends on ssc_pkg and ssc_lane
module ssc_core import ssc_pkg::*; (
  input  logic [2:0]    flow_dir,
  input  logic [2:0]    stream_dir,
  input  logic [NB-1:0] neighbour_valid,
  input  logic [23:0]   neighbour_dirs,
  output logic          on_left,
  output logic          on_right
);

  lane_res_t     lane_res [NB];
  logic [NB-1:0] trib;
  logic [NB-1:0] right;
  logic          opposite;
  logic          all_right;
  logic          none_right;
  logic          undet;

  // one lane per neighbour position
  for (genvar g = 0; g < NB; g++) begin : g_lane
    ssc_lane u_lane (
      .idx        (3'(g)),
      .flow_dir   (flow_dir),
      .stream_dir (stream_dir),
      .nb_valid   (neighbour_valid[g]),
      .nb_dir     (neighbour_dirs[3*g +: 3]),
      .res        (lane_res[g])
    );
    assign trib[g]  = lane_res[g].trib;
    assign right[g] = lane_res[g].right;
  end

  // tributaries must all agree, else the line lies between two of them
  assign opposite   = (stream_dir == opp_dir(flow_dir));
  assign all_right  = ((trib & right) == trib);
  assign none_right = ((trib & right) == '0);
  assign undet      = opposite || (trib == '0) || !(all_right || none_right);

  assign on_right = undet || all_right;
  assign on_left  = undet || !all_right;

endmodule

// File: src/stream_side_classifier.sv
// top level of the stream side classifier: input stage, decision logic, output register
// depends on ssc_pkg and ssc_core
//
// Decides on which side of a stream a flow line enters, from the flow
// direction, the stream cell's d8 direction and its eight neighbours. One
// word is accepted every clock cycle; an accepted word is held in the input
// stage register, then the output register takes the decision and offers
// the result, and the whole neighbourhood is judged in one pass of the
// eight-lane decision logic between them. The input stalls only while both
// registers hold a word and m_tready is low. Both on_left and on_right set
// means the side is undetermined (opposite flow, channel head or
// disagreeing tributaries).
module stream_side_classifier import ssc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // flow_dir[2:0], stream_dir[5:3], neighbour_valid[13:6],
  // neighbour_dirs[37:14], zero[39:38]
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // on_left[0], on_right[1], zero[7:2]
  output logic [OUT_W-1:0] m_tdata
);

  logic          s1_valid;
  logic [2:0]    s1_flow_dir;
  logic [2:0]    s1_stream_dir;
  logic [NB-1:0] s1_nb_valid;
  logic [23:0]   s1_nb_dirs;
  logic          on_left;
  logic          on_right;
  logic          out_free;
  logic          s1_take;

  // stage flow control
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || out_free;
  assign s1_take  = s_tvalid && s_tready;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_flow_dir   <= s_tdata[2:0];
      s1_stream_dir <= s_tdata[5:3];
      s1_nb_valid   <= s_tdata[13:6];
      s1_nb_dirs    <= s_tdata[37:14];
    end
  end

  // side decision
  ssc_core u_core (
    .flow_dir        (s1_flow_dir),
    .stream_dir      (s1_stream_dir),
    .neighbour_valid (s1_nb_valid),
    .neighbour_dirs  (s1_nb_dirs),
    .on_left         (on_left),
    .on_right        (on_right)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      m_tdata <= {{(OUT_W-2){1'b0}}, on_right, on_left};
    end
  end

endmodule

// File: src/ssc_checker.sv
// port-level checker for the stream side classifier and its bind
// depends on ssc_pkg and assert_macros.svh
`include "assert_macros.svh"

module ssc_checker import ssc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // a stalled result word stays offered and unchanged
  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // at least one side flag is set in every offered result word
  `ASSERT_CLK(a_side_set, clk, rst, m_tvalid |-> (m_tdata[0] || m_tdata[1]))

  // padding bits of a result word are zero
  `ASSERT_CLK(a_pad_zero, clk, rst, m_tvalid |-> (m_tdata[OUT_W-1:2] == '0))

  // nothing is offered right after reset
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid)

  // an empty output register never blocks the input
  `ASSERT_CLK(a_ready_free, clk, rst, !m_tvalid |-> s_tready)

endmodule

bind stream_side_classifier ssc_checker u_ssc_checker (.*);
